FILE: hdl/gcd_lcm_unit_defines.svh
// Assertion macros used by the top level of the divisor and multiple unit.
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define GCU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define GCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gcu_pkg.sv
// Package with the types and constants of the divisor and multiple unit.
package gcu_pkg;

    localparam int GCU_OPERAND_WIDTH = 32;
    localparam int OPERAND_W         = 32;
    localparam int DIVISOR_W         = 32;
    localparam int MULTIPLE_W        = 64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TWOS,
        S_STRIP,
        S_GCD,
        S_SCALE,
        S_DIV,
        S_MULI,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HALVE_BOTH,
        OP_HALVE_A,
        OP_HALVE_B,
        OP_SWAP,
        OP_SUB,
        OP_SCALE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_PUBLISH
    } t_op;

    typedef enum logic [1:0] {
        ALU_CMP,
        ALU_DIV,
        ALU_MUL
    } t_alu_sel;

    typedef struct packed {
        t_op      op;
        t_alu_sel alu;
    } t_dp_ctrl;

    typedef struct packed {
        logic in_zero;
        logic a_odd;
        logic b_odd;
        logic b_lt_a;
        logic b_eq_a;
        logic k_zero;
    } t_dp_stat;

endpackage

FILE: hdl/gcu_if.sv
// Handshake channels carrying operand words in and result words out.
interface gcu_in_if import gcu_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OPERAND_W-1:0] operand_a;
    logic [OPERAND_W-1:0] operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface gcu_out_if import gcu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [DIVISOR_W-1:0]  divisor;
    logic [MULTIPLE_W-1:0] multiple;
    logic                  operand_error;

    modport source (output valid, output divisor, output multiple, output operand_error,
                    input ready);
    modport sink   (input valid, input divisor, input multiple, input operand_error,
                    output ready);
endinterface

FILE: hdl/gcu_alu.sv
// Shared adder and subtractor used by the comparison, division and product phases.
module gcu_alu import gcu_pkg::*; #(
    parameter int W = GCU_OPERAND_WIDTH
) (
    input  logic [W:0] i_x,
    input  logic [W:0] i_y,
    input  logic       i_sub,
    output logic [W:0] o_sum,
    output logic       o_carry
);

    logic [W+1:0] w_full;

    // Subtraction is x plus the inverted y plus one; carry set means no borrow.
    assign w_full  = {1'b0, i_x} + {1'b0, (i_y ^ {(W+1){i_sub}})} + (W+2)'(i_sub);
    assign o_sum   = w_full[W:0];
    assign o_carry = w_full[W+1];

endmodule

FILE: hdl/gcu_dp.sv
// Datapath registers of the divisor and multiple unit around the shared adder.
module gcu_dp import gcu_pkg::*; #(
    parameter int W = GCU_OPERAND_WIDTH
) (
    input  logic                  i_clk,
    input  logic [OPERAND_W-1:0]  i_operand_a,
    input  logic [OPERAND_W-1:0]  i_operand_b,
    input  t_dp_ctrl              i_ctrl,
    output t_dp_stat              o_stat,
    output logic [DIVISOR_W-1:0]  o_divisor,
    output logic [MULTIPLE_W-1:0] o_multiple,
    output logic                  o_operand_error
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  r_a, r_b, r_oa, r_ob, r_rem, r_q;
    logic [CW-1:0] r_k;
    logic          r_err;
    logic [DIVISOR_W-1:0]  r_div_o;
    logic [MULTIPLE_W-1:0] r_mul_o;
    logic                  r_err_o;

    logic [W:0] w_x, w_y, w_sum;
    logic       w_sub, w_carry;
    logic [W-1:0] w_in_a, w_in_b;

    assign w_in_a = i_operand_a[W-1:0];
    assign w_in_b = i_operand_b[W-1:0];

    always_comb begin
        w_x   = '0;
        w_y   = '0;
        w_sub = 1'b0;
        case (i_ctrl.alu)
            ALU_CMP: begin
                w_x   = {1'b0, r_b};
                w_y   = {1'b0, r_a};
                w_sub = 1'b1;
            end
            ALU_DIV: begin
                w_x   = {r_rem, r_q[W-1]};
                w_y   = {1'b0, r_a};
                w_sub = 1'b1;
            end
            ALU_MUL: begin
                w_x   = {1'b0, r_rem};
                w_y   = r_q[0] ? {1'b0, r_ob} : '0;
                w_sub = 1'b0;
            end
            default: begin
                w_x   = '0;
            end
        endcase
    end

    gcu_alu #(.W(W)) u_alu (
        .i_x     (w_x),
        .i_y     (w_y),
        .i_sub   (w_sub),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    assign o_stat.in_zero = (w_in_a == '0) || (w_in_b == '0);
    assign o_stat.a_odd   = r_a[0];
    assign o_stat.b_odd   = r_b[0];
    assign o_stat.b_lt_a  = !w_carry;
    assign o_stat.b_eq_a  = w_carry && (w_sum[W-1:0] == '0);
    assign o_stat.k_zero  = (r_k == '0);

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LOAD: begin
                r_a   <= w_in_a;
                r_b   <= w_in_b;
                r_oa  <= w_in_a;
                r_ob  <= w_in_b;
                r_k   <= '0;
                r_err <= (w_in_a == '0) || (w_in_b == '0);
            end
            OP_HALVE_BOTH: begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end
            OP_HALVE_A: begin
                r_a <= r_a >> 1;
            end
            OP_HALVE_B: begin
                r_b <= r_b >> 1;
            end
            OP_SWAP: begin
                r_a <= r_b;
                r_b <= r_a;
            end
            OP_SUB: begin
                r_b <= w_sum[W-1:0];
            end
            OP_SCALE: begin
                r_a <= r_a << 1;
                r_k <= r_k - 1'b1;
            end
            OP_DIV_INIT: begin
                r_rem <= '0;
                r_q   <= r_oa;
            end
            OP_DIV_STEP: begin
                // Restoring division: keep the difference only when nothing was borrowed.
                r_rem <= w_carry ? w_sum[W-1:0] : w_x[W-1:0];
                r_q   <= {r_q[W-2:0], w_carry};
            end
            OP_MUL_INIT: begin
                r_rem <= '0;
            end
            OP_MUL_STEP: begin
                r_rem <= w_sum[W:1];
                r_q   <= {w_sum[0], r_q[W-1:1]};
            end
            OP_PUBLISH: begin
                r_div_o <= r_err ? '0 : DIVISOR_W'(r_a);
                r_mul_o <= r_err ? '0 : MULTIPLE_W'({r_rem, r_q});
                r_err_o <= r_err;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_divisor       = r_div_o;
    assign o_multiple      = r_mul_o;
    assign o_operand_error = r_err_o;

endmodule

FILE: hdl/gcu_ctrl.sv
// Sequencer that steps the datapath through divisor, division and product phases.
module gcu_ctrl import gcu_pkg::*; #(
    parameter int W = GCU_OPERAND_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl,
    output t_state   o_state
);

    localparam int            CW   = $clog2(W);
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic          r_out_valid;
    logic          w_last, w_free;

    assign w_last = (r_cnt == LAST);
    assign w_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) begin
                         n_state = i_stat.in_zero ? S_DONE : S_TWOS;
                     end
            S_TWOS:  if (i_stat.a_odd || i_stat.b_odd) begin
                         n_state = S_STRIP;
                     end
            S_STRIP: if (i_stat.a_odd) begin
                         n_state = S_GCD;
                     end
            S_GCD:   if (i_stat.b_odd && !i_stat.b_lt_a && i_stat.b_eq_a) begin
                         n_state = S_SCALE;
                     end
            S_SCALE: if (i_stat.k_zero) begin
                         n_state = S_DIV;
                     end
            S_DIV:   if (w_last) begin
                         n_state = S_MULI;
                     end
            S_MULI:  n_state = S_MUL;
            S_MUL:   if (w_last) begin
                         n_state = S_DONE;
                     end
            S_DONE:  if (w_free) begin
                         n_state = S_IDLE;
                     end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ctrl.op  = OP_NONE;
        o_ctrl.alu = ALU_CMP;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.op = OP_LOAD;
                end
            end
            S_TWOS: begin
                if (!i_stat.a_odd && !i_stat.b_odd) begin
                    o_ctrl.op = OP_HALVE_BOTH;
                end
            end
            S_STRIP: begin
                if (!i_stat.a_odd) begin
                    o_ctrl.op = OP_HALVE_A;
                end
            end
            S_GCD: begin
                if (!i_stat.b_odd) begin
                    o_ctrl.op = OP_HALVE_B;
                end else if (i_stat.b_lt_a) begin
                    o_ctrl.op = OP_SWAP;
                end else if (!i_stat.b_eq_a) begin
                    o_ctrl.op = OP_SUB;
                end
            end
            S_SCALE: begin
                o_ctrl.op = i_stat.k_zero ? OP_DIV_INIT : OP_SCALE;
            end
            S_DIV: begin
                o_ctrl.op  = OP_DIV_STEP;
                o_ctrl.alu = ALU_DIV;
            end
            S_MULI: begin
                o_ctrl.op = OP_MUL_INIT;
            end
            S_MUL: begin
                o_ctrl.op  = OP_MUL_STEP;
                o_ctrl.alu = ALU_MUL;
            end
            S_DONE: begin
                if (w_free) begin
                    o_ctrl.op = OP_PUBLISH;
                end
            end
            default: begin
                o_ctrl.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctrl.op == OP_DIV_INIT || o_ctrl.op == OP_MUL_INIT) begin
                r_cnt <= '0;
            end else if (o_ctrl.op == OP_DIV_STEP || o_ctrl.op == OP_MUL_STEP) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (o_ctrl.op == OP_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

endmodule

FILE: hdl/gcd_lcm_unit.sv
// Top level of the greatest common divisor and least common multiple unit.
//
//  Channel  Direction  Contents of one word
//  i_in     in         operand_a (32), operand_b (32)
//  o_out    out        divisor (32), multiple (64), operand_error (1)
//
// The time one word takes depends on the operands; the comparisons, subtractions and
// the division and product steps go through one shared adder, once a cycle.
// The divisor is found by the binary method, then a/divisor is formed one quotient bit
// a cycle and multiplied by b one bit a cycle.
// A zero operand skips straight to the result.
// Reset is synchronous, active low; it clears the sequencer and the result valid flag.
// A finished result waits in the output register while the next word is accepted.
`include "gcd_lcm_unit_defines.svh"

module gcd_lcm_unit import gcu_pkg::*; #(
    parameter int OPERAND_WIDTH = GCU_OPERAND_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcu_in_if.sink     i_in,
    gcu_out_if.source  o_out
);

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;
    t_state   w_state;
    logic     w_in_ready;
    logic     w_out_valid;

    // The sequencer decides each cycle which datapath operation runs and how the
    // shared adder's operands are selected.
    gcu_ctrl #(.W(OPERAND_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl),
        .o_state     (w_state)
    );

    // The datapath holds the working operands, the originals, the count of shared
    // factors of two and the output register.
    gcu_dp #(.W(OPERAND_WIDTH)) u_dp (
        .i_clk           (i_clk),
        .i_operand_a     (i_in.operand_a),
        .i_operand_b     (i_in.operand_b),
        .i_ctrl          (w_ctrl),
        .o_stat          (w_stat),
        .o_divisor       (o_out.divisor),
        .o_multiple      (o_out.multiple),
        .o_operand_error (o_out.operand_error)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // A word with a zero operand goes straight to the result stage.
    `GCU_ASSERT_NEXT(a_zero_to_done, i_clk, i_rst_n,
        i_in.valid && i_in.ready && (i_in.operand_a[OPERAND_WIDTH-1:0] == '0 ||
        i_in.operand_b[OPERAND_WIDTH-1:0] == '0),
        w_state == S_DONE, "zero operand did not go straight to the result")

    // The output register is only overwritten once its word has gone.
    `GCU_ASSERT_SAME(a_publish_free, i_clk, i_rst_n, w_ctrl.op == OP_PUBLISH,
        !o_out.valid || o_out.ready, "result overwritten before it was taken")

    // An error result carries zeros.
    `GCU_ASSERT_SAME(a_error_zero, i_clk, i_rst_n, o_out.valid && o_out.operand_error,
        o_out.divisor == '0 && o_out.multiple == '0, "error result is not zero")

    // A valid result always has a non-zero divisor and multiple.
    `GCU_ASSERT_SAME(a_result_nonzero, i_clk, i_rst_n, o_out.valid && !o_out.operand_error,
        o_out.divisor != '0 && o_out.multiple != '0, "valid result has a zero field")

endmodule

FILE: dv/gcd_lcm_unit_tb.sv
// Self-checking testbench for the greatest common divisor and least common multiple unit.
`timescale 1ns / 1ps

module gcd_lcm_unit_tb;
    import gcu_pkg::*;

    // The block under test uses every bit of each operand.
    localparam int OPW = GCU_OPERAND_WIDTH;
    localparam logic [63:0] OPERAND_MASK = (64'd1 << OPW) - 64'd1;

    // Cycles to watch for stray results once every expected result has arrived.
    localparam int DRAIN_CYCLES = 250;
    // The long receiver hold-off must comfortably outlast two words of work.
    localparam int HOLD_CYCLES  = 600;
    // Cycles without any accepted word before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    localparam int SHOW_LIMIT   = 10;

    typedef struct {
        logic [DIVISOR_W-1:0]  divisor;
        logic [MULTIPLE_W-1:0] multiple;
        logic                  operand_error;
    } t_gcd_lcm;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gcu_in_if  in_if ();
    gcu_out_if out_if ();

    gcd_lcm_unit #(
        .OPERAND_WIDTH (OPW)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Expected results of accepted operand words, oldest first.
    t_gcd_lcm    pending_results[$];
    int unsigned fault_count = 0;
    // When clear, neither side inserts idle bursts.
    bit          idling_on   = 1'b1;
    // Asks the receiver for one long hold-off of its ready line.
    bit          hold_req    = 1'b0;

    // Euclid on the masked operands; the multiple is (a / g) * b at 64 bits, which is exact.
    function automatic t_gcd_lcm predict_gcd_lcm(logic [OPERAND_W-1:0] a_in,
                                                 logic [OPERAND_W-1:0] b_in);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] r;
        t_gcd_lcm    res;
        a = {32'd0, a_in} & OPERAND_MASK;
        b = {32'd0, b_in} & OPERAND_MASK;
        if (a == 64'd0 || b == 64'd0) begin
            res.divisor       = '0;
            res.multiple      = '0;
            res.operand_error = 1'b1;
        end else begin
            x = a;
            y = b;
            while (y != 64'd0) begin
                r = x % y;
                x = y;
                y = r;
            end
            res.divisor       = x[DIVISOR_W-1:0];
            res.multiple      = (a / x) * b;
            res.operand_error = 1'b0;
        end
        return res;
    endfunction

    // Every failure is counted; only the first few are described.
    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= SHOW_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Offers one operand word, after an optional idle burst, and waits until it is taken.
    // The expectation is queued at the edge at which the block accepts the word.
    task automatic send_word(input logic [OPERAND_W-1:0] a, input logic [OPERAND_W-1:0] b);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk);
                in_if.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.operand_a <= a;
        in_if.operand_b <= b;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        pending_results.push_back(predict_gcd_lcm(a, b));
    endtask

    // Random operand pairs, shaped so that common factors, powers of two and equal
    // operands turn up far more often than uniform values would give them.
    task automatic pick_operands(output logic [OPERAND_W-1:0] a,
                                 output logic [OPERAND_W-1:0] b);
        logic [31:0] g;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                a = $urandom;
                b = $urandom;
            end
            4, 5: begin
                g = $urandom_range(1, 65535);
                a = g * $urandom_range(1, 65535);
                b = g * $urandom_range(1, 65535);
            end
            6: begin
                a = $urandom;
                b = a;
            end
            7: begin
                a = 32'd1 << $urandom_range(0, 31);
                b = $urandom << $urandom_range(0, 31);
            end
            8: begin
                a = $urandom_range(0, 64);
                b = $urandom_range(0, 64);
            end
            default: begin
                a = $urandom;
                b = $urandom_range(1, 16);
            end
        endcase
    endtask

    // A zero operand on either side, or both, must give the error flag and zero fields.
    task automatic test_zero_operands();
        send_word(32'd0, 32'd0);
        send_word(32'd0, 32'd5);
        send_word(32'd7, 32'd0);
        send_word(32'd0, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'd0);
        send_word(32'h8000_0000, 32'd0);
    endtask

    // Extremes of both fields, including the largest possible multiple.
    task automatic test_extremes();
        send_word(32'd1, 32'd1);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'd1, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'd1);
        send_word(32'h8000_0000, 32'h8000_0000);
        send_word(32'h8000_0000, 32'd1);
        send_word(32'hFFFF_FFFF, 32'h8000_0000);
        send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        // Two large primes, so the multiple fills nearly all 64 bits.
        send_word(32'd4294967291, 32'd4294967279);
    endtask

    // Equal operands and pairs sharing large factors or powers of two.
    task automatic test_shared_factors();
        send_word(32'd12345, 32'd12345);
        send_word(32'hDEAD_BEEF, 32'hDEAD_BEEF);
        send_word(32'hC000_0000, 32'h4000_0000);
        send_word(32'h5555_5555, 32'hAAAA_AAAA);
        send_word(32'd65535 * 32'd65521, 32'd65535 * 32'd65519);
        send_word(32'd48, 32'd180);
    endtask

    task automatic test_random_words(input int count);
        logic [OPERAND_W-1:0] a;
        logic [OPERAND_W-1:0] b;
        repeat (count) begin
            pick_operands(a, b);
            send_word(a, b);
        end
    endtask

    // The receiver stops taking results for a long while; the sender keeps offering
    // words, so the block fills up and must hold its input off.
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random_words(10);
    endtask

    // The closing stretch runs with both sides always willing.
    task automatic test_back_to_back();
        idling_on = 1'b0;
        test_random_words(70);
    endtask

    // Receiver: random stall bursts, plus the one long hold-off when it is asked for.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned hold_left;
        logic        rdy;
        stall_left   = 0;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                rdy       = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                rdy        = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_if.ready <= rdy;
        end
    end

    // Each result word is compared field by field with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_gcd_lcm want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_fault($sformatf("result word with none expected: div %0h mul %0h err %0b",
                                       out_if.divisor, out_if.multiple, out_if.operand_error));
            end else begin
                want = pending_results.pop_front();
                if (out_if.divisor !== want.divisor) begin
                    report_fault($sformatf("divisor expected %0h got %0h",
                                           want.divisor, out_if.divisor));
                end
                if (out_if.multiple !== want.multiple) begin
                    report_fault($sformatf("multiple expected %0h got %0h",
                                           want.multiple, out_if.multiple));
                end
                if (out_if.operand_error !== want.operand_error) begin
                    report_fault($sformatf("operand_error expected %0b got %0b",
                                           want.operand_error, out_if.operand_error));
                end
            end
        end
    end

    // Watchdog: the run is hung if no word moves on either channel for too long.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin : main
        in_if.valid     = 1'b0;
        in_if.operand_a = '0;
        in_if.operand_b = '0;
        i_rst_n         = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_operands();
        test_extremes();
        test_shared_factors();
        test_random_words(449);
        test_backpressure();
        test_back_to_back();

        @(negedge i_clk);
        in_if.valid <= 1'b0;

        // Drain: wait for every expected result, then watch a while for strays.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/gcu_pkg.sv
hdl/gcu_if.sv
hdl/gcu_alu.sv
hdl/gcu_dp.sv
hdl/gcu_ctrl.sv
hdl/gcd_lcm_unit.sv
dv/gcd_lcm_unit_tb.sv
